// ===== hw/rtl/plc_il_pkg.sv =====
// Shared action codes, result type and logic-op helper for the PLC instruction-list unit.
package plc_il_pkg;

    // Instruction action codes
    localparam logic [4:0] ACT_NOP   = 5'd0;
    localparam logic [4:0] ACT_LD    = 5'd1;
    localparam logic [4:0] ACT_ST    = 5'd2;
    localparam logic [4:0] ACT_S     = 5'd3;
    localparam logic [4:0] ACT_R     = 5'd4;
    localparam logic [4:0] ACT_AND   = 5'd5;
    localparam logic [4:0] ACT_OR    = 5'd6;
    localparam logic [4:0] ACT_XOR   = 5'd7;
    localparam logic [4:0] ACT_GT    = 5'd8;
    localparam logic [4:0] ACT_GE    = 5'd9;
    localparam logic [4:0] ACT_EQ    = 5'd10;
    localparam logic [4:0] ACT_NE    = 5'd11;
    localparam logic [4:0] ACT_LT    = 5'd12;
    localparam logic [4:0] ACT_LE    = 5'd13;
    localparam logic [4:0] ACT_CLOSE = 5'd14;
    localparam logic [4:0] ACT_JMP   = 5'd15;
    localparam logic [4:0] ACT_RET   = 5'd16;
    localparam logic [4:0] ACT_SCAN  = 5'd17;

    // Operand areas
    localparam logic [1:0] AREA_NONE = 2'd0;
    localparam logic [1:0] AREA_IN   = 2'd1;
    localparam logic [1:0] AREA_OUT  = 2'd2;
    localparam logic [1:0] AREA_MRK  = 2'd3;

    // Field widths
    localparam int ACTION_W = 5;
    localparam int AREA_W   = 2;
    localparam int BIT_W    = 3;
    localparam int INDEX_W  = 8;
    localparam int PINS_W   = 8;
    localparam int OUTB_W   = 8;
    localparam int OP_W     = 4;

    // One result beat
    typedef struct packed {
        logic               accumulator_value;
        logic [OUTB_W-1:0]  output_bits;
        logic               branch_taken;
        logic [INDEX_W-1:0] next_index;
        logic               stack_error;
    } res_t;

    // acc OP operand for immediate ops, saved OP acc for a close
    function automatic logic logic_op(input logic [4:0] op, input logic a, input logic b);
        logic r;
        case (op)
            ACT_AND: r = a & b;
            ACT_OR:  r = a | b;
            ACT_XOR: r = a ^ b;
            ACT_GT:  r = a & ~b;
            ACT_GE:  r = a | ~b;
            ACT_EQ:  r = ~(a ^ b);
            ACT_NE:  r = a ^ b;
            ACT_LT:  r = ~a & b;
            ACT_LE:  r = ~a | b;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/plc_il_in_if.sv =====
// Instruction channel: one decoded instruction per beat.
interface plc_il_in_if
    import plc_il_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                negate;
    logic                conditional;
    logic                deferred;
    logic [AREA_W-1:0]   area;
    logic [BIT_W-1:0]    bit_index;
    logic [INDEX_W-1:0]  jump_target;
    logic [INDEX_W-1:0]  instruction_index;
    logic [PINS_W-1:0]   pin_values;

    modport source (
        output valid, action, negate, conditional, deferred, area, bit_index,
               jump_target, instruction_index, pin_values,
        input  ready
    );
    modport sink (
        input  valid, action, negate, conditional, deferred, area, bit_index,
               jump_target, instruction_index, pin_values,
        output ready
    );
endinterface

// ===== hw/rtl/plc_il_out_if.sv =====
// Result channel: accumulator, output image and branch info per beat.
interface plc_il_out_if
    import plc_il_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accumulator_value;
    logic [OUTB_W-1:0]  output_bits;
    logic               branch_taken;
    logic [INDEX_W-1:0] next_index;
    logic               stack_error;

    modport source (
        output valid, accumulator_value, output_bits, branch_taken, next_index, stack_error,
        input  ready
    );
    modport sink (
        input  valid, accumulator_value, output_bits, branch_taken, next_index, stack_error,
        output ready
    );
endinterface

// ===== hw/rtl/plc_instruction_list_unit.sv =====
// Top level: one-bit-accumulator instruction-list processor with two-entry result buffer.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   cmd     | in  | action, negate, conditional, deferred, area, bit_index,
//           |     | jump_target, instruction_index, pin_values
//   res     | out | accumulator_value, output_bits, branch_taken, next_index,
//           |     | stack_error
//
// One instruction per cycle while cmd.ready is high; its result is registered at accept.
// All state (accumulator, images, stack, return index) updates at the accept edge.
// A result register plus a skid register hold up to two results; cmd.ready drops only
// when both are full, so a stalled result sink still lets one more instruction in.
// rst_n clears accumulator, images, return index and stack level; stack entries are
// not cleared since an entry is read only after it was pushed.
module plc_instruction_list_unit
    import plc_il_pkg::*;
#(
    parameter int STACK_DEPTH  = 8,
    parameter int PROGRAM_SIZE = 256,
    parameter int AREA_BITS    = 8
) (
    input  logic clk,
    input  logic rst_n,
    plc_il_in_if.sink    cmd,
    plc_il_out_if.source res
);

    localparam int IMG_W = (AREA_BITS > OUTB_W) ? AREA_BITS : OUTB_W;
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Architectural state
    logic                 acc_reg, acc_next;
    logic [AREA_BITS-1:0] in_img_reg, in_img_next;
    logic [AREA_BITS-1:0] out_img_reg, out_img_next;
    logic [AREA_BITS-1:0] mrk_img_reg, mrk_img_next;
    logic [INDEX_W-1:0]   ret_reg, ret_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic                 sv_val_reg [STACK_DEPTH];
    logic [OP_W-1:0]      sv_op_reg  [STACK_DEPTH];

    // Result buffer
    logic out_valid_reg, skid_valid_reg;
    res_t out_data_reg, skid_data_reg;
    res_t res_new;

    logic             cmd_fire, res_pop, push_en;
    logic [IDX_W-1:0] push_idx, pop_idx;
    logic [LVL_W-1:0] lvl_m1;

    assign cmd.ready = !skid_valid_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign res_pop   = out_valid_reg && res.ready;

    assign lvl_m1   = lvl_reg - LVL_W'(1);
    assign push_idx = lvl_reg[IDX_W-1:0];
    assign pop_idx  = lvl_m1[IDX_W-1:0];

    // Execute one instruction
    always_comb
    begin
        logic [IMG_W-1:0] in_ext, out_ext, mrk_ext, sel_ext, bit_mask, pins_ext;
        logic             bit_ok, value, wr_val, wr_en, go, is_logic;

        in_ext   = IMG_W'(in_img_reg);
        out_ext  = IMG_W'(out_img_reg);
        mrk_ext  = IMG_W'(mrk_img_reg);
        pins_ext = IMG_W'(cmd.pin_values);
        bit_ok   = 32'(cmd.bit_index) < 32'(AREA_BITS);
        bit_mask = bit_ok ? (IMG_W'(1) << cmd.bit_index) : '0;

        case (cmd.area)
            AREA_IN:  sel_ext = in_ext;
            AREA_OUT: sel_ext = out_ext;
            AREA_MRK: sel_ext = mrk_ext;
            default:  sel_ext = '0;
        endcase
        value    = (|(sel_ext & bit_mask)) ^ cmd.negate;
        is_logic = cmd.action inside {[ACT_AND:ACT_LE]};

        acc_next = acc_reg;
        ret_next = ret_reg;
        lvl_next = lvl_reg;
        push_en  = 1'b0;
        wr_en    = 1'b0;
        wr_val   = 1'b0;
        go       = 1'b0;
        res_new  = '0;

        if (is_logic && cmd.deferred)
        begin
            if (32'(lvl_reg) >= 32'(STACK_DEPTH))
            begin
                res_new.stack_error = 1'b1;
            end
            else
            begin
                push_en  = 1'b1;
                lvl_next = lvl_reg + LVL_W'(1);
                acc_next = value;
            end
        end
        else
        begin
            case (cmd.action)
                ACT_LD: acc_next = value;
                ACT_ST:
                begin
                    wr_en  = 1'b1;
                    wr_val = acc_reg ^ cmd.negate;
                end
                ACT_S:
                begin
                    wr_en  = 1'b1;
                    wr_val = 1'b1;
                end
                ACT_R:  wr_en = 1'b1;
                ACT_CLOSE:
                begin
                    if (lvl_reg == '0)
                    begin
                        res_new.stack_error = 1'b1;
                    end
                    else
                    begin
                        lvl_next = lvl_m1;
                        acc_next = logic_op({1'b0, sv_op_reg[pop_idx]},
                                            sv_val_reg[pop_idx], acc_reg);
                    end
                end
                ACT_JMP:
                begin
                    ret_next = cmd.instruction_index;
                    if (cmd.conditional)
                        go = acc_reg;
                    else if (cmd.negate)
                        go = !acc_reg;
                    else
                        go = 1'b1;
                    if (go && (32'(cmd.jump_target) < 32'(PROGRAM_SIZE)))
                    begin
                        res_new.branch_taken = 1'b1;
                        res_new.next_index   = cmd.jump_target;
                    end
                end
                ACT_RET:
                begin
                    go = (!cmd.conditional && !cmd.negate) || (cmd.conditional && acc_reg)
                         || (cmd.negate && !acc_reg);
                    if (go)
                    begin
                        res_new.branch_taken = 1'b1;
                        res_new.next_index   = ret_reg + INDEX_W'(1);
                    end
                end
                ACT_SCAN: in_ext = pins_ext;
                default:
                begin
                    if (is_logic)
                        acc_next = logic_op(cmd.action, acc_reg, value);
                end
            endcase
        end

        // Bit write into the selected image
        if (wr_en)
        begin
            case (cmd.area)
                AREA_IN:  in_ext  = wr_val ? (in_ext | bit_mask)  : (in_ext & ~bit_mask);
                AREA_OUT: out_ext = wr_val ? (out_ext | bit_mask) : (out_ext & ~bit_mask);
                AREA_MRK: mrk_ext = wr_val ? (mrk_ext | bit_mask) : (mrk_ext & ~bit_mask);
                default:  ;
            endcase
        end

        in_img_next  = in_ext[AREA_BITS-1:0];
        out_img_next = out_ext[AREA_BITS-1:0];
        mrk_img_next = mrk_ext[AREA_BITS-1:0];

        res_new.accumulator_value = acc_next;
        res_new.output_bits       = out_ext[OUTB_W-1:0];
    end

    // State and buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= 1'b0;
            in_img_reg     <= '0;
            out_img_reg    <= '0;
            mrk_img_reg    <= '0;
            ret_reg        <= '0;
            lvl_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                acc_reg     <= acc_next;
                in_img_reg  <= in_img_next;
                out_img_reg <= out_img_next;
                mrk_img_reg <= mrk_img_next;
                ret_reg     <= ret_next;
                lvl_reg     <= lvl_next;
            end
            if (!out_valid_reg || res_pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= cmd_fire;
                end
            end
            else if (cmd_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Stack entries and result payloads
    always_ff @(posedge clk)
    begin
        if (cmd_fire && push_en)
        begin
            sv_val_reg[push_idx] <= acc_reg;
            sv_op_reg[push_idx]  <= cmd.action[OP_W-1:0];
        end
        if (!out_valid_reg || res_pop)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (cmd_fire)
                out_data_reg <= res_new;
        end
        else if (cmd_fire)
        begin
            skid_data_reg <= res_new;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.accumulator_value = out_data_reg.accumulator_value;
    assign res.output_bits       = out_data_reg.output_bits;
    assign res.branch_taken      = out_data_reg.branch_taken;
    assign res.next_index        = out_data_reg.next_index;
    assign res.stack_error       = out_data_reg.stack_error;

`ifndef SYNTHESIS
    // Skid entry only holds a result behind a waiting head
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid valid without head valid");

    // Stack level stays within depth
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lvl_reg) <= 32'(STACK_DEPTH))
        else $error("stack level above depth");

    // A stack error leaves the level unchanged
    a_err_keeps_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && res_new.stack_error) |=> $stable(lvl_reg))
        else $error("stack level moved on stack error");

    // No branch, no destination
    a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && !res_new.branch_taken) |-> (res_new.next_index == '0))
        else $error("next index set without branch");

    // An accept into an empty buffer shows a result next cycle
    a_fill_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && !out_valid_reg) |=> out_valid_reg)
        else $error("accepted beat did not reach result register");
`endif

endmodule
